FILE: sv/ets_pkg.sv
// ============================================================================
// ets_pkg
// Types and constants shared by the expression token scanner modules.
// ============================================================================
`timescale 1ns / 1ps

package ets_pkg;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_INT   = 3'd1,
        MODE_DOT   = 3'd2,
        MODE_FRAC  = 3'd3,
        MODE_IDENT = 3'd4,
        MODE_STAR  = 3'd5,
        MODE_HALT  = 3'd6
    } mode_t;

    // token kinds
    typedef enum logic [3:0] {
        KIND_END    = 4'd0,
        KIND_ERROR  = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_IDENT  = 4'd3,
        KIND_PLUS   = 4'd4,
        KIND_MINUS  = 4'd5,
        KIND_STAR   = 4'd6,
        KIND_SLASH  = 4'd7,
        KIND_POWER  = 4'd8,
        KIND_LPAREN = 4'd9,
        KIND_RPAREN = 4'd10
    } kind_t;

    // character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam logic [5:0] FRAC_MAX = 6'd63;

    // token queue geometry
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_ADDR_BITS = 2;
    localparam int QUEUE_CNT_BITS  = 3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [63:0] mantissa;
        logic [5:0]  fraction_digits;
        logic        mantissa_overflow;
    } out_item_t;

    // tokens produced by one accepted item, in order
    typedef struct packed {
        logic      first_valid;
        logic      second_valid;
        out_item_t first_tok;
        out_item_t second_tok;
    } emit_t;

endpackage

FILE: sv/ets_scan_core.sv
// ============================================================================
// ets_scan_core
// Scanner state and the per-byte update; yields up to two tokens per item.
// ============================================================================
`timescale 1ns / 1ps

module ets_scan_core
    import ets_pkg::*;
#(
    parameter int OFFSET_BITS   = 32,
    parameter int MANTISSA_BITS = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output emit_t    emit
);

    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   start_reg, start_next;
    logic [MANTISSA_BITS-1:0] acc_reg, acc_next;
    logic [5:0]               frac_reg, frac_next;
    logic                     ovf_reg, ovf_next;
    mode_t                    mode_reg, mode_next;

    // token record builder
    function automatic out_item_t make_tok(input kind_t kind,
                                           input logic [OFFSET_BITS-1:0] start,
                                           input logic [OFFSET_BITS-1:0] len,
                                           input logic [MANTISSA_BITS-1:0] mant,
                                           input logic [5:0] frac,
                                           input logic ovf);
        out_item_t t;
        t.token_kind        = kind;
        t.start_offset      = 32'(start);
        t.token_length      = 32'(len);
        t.mantissa          = 64'(mant);
        t.fraction_digits   = frac;
        t.mantissa_overflow = ovf;
        return t;
    endfunction

    // acc * 10 + d, saturating at the mantissa width
    function automatic logic [MANTISSA_BITS:0] mac10(input logic [MANTISSA_BITS-1:0] acc,
                                                     input logic [3:0] d);
        logic [MANTISSA_BITS+3:0] wide;
        logic [MANTISSA_BITS:0]   r;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (MANTISSA_BITS+4)'(d);
        if (wide[MANTISSA_BITS+3:MANTISSA_BITS] != 4'd0) begin
            r = {1'b1, {MANTISSA_BITS{1'b1}}};
        end
        else begin
            r = {1'b0, wide[MANTISSA_BITS-1:0]};
        end
        return r;
    endfunction

    logic [7:0]               c;
    logic [3:0]               dval;
    logic                     is_digit, is_alpha, is_space;
    logic [OFFSET_BITS-1:0]   cur, prev;
    logic [OFFSET_BITS-1:0]   len_cur, len_prev;
    logic [MANTISSA_BITS:0]   mac;
    logic                     scan;
    logic                     flush_v, byte_v;
    out_item_t                flush_tok, byte_tok;
    out_item_t                num_cur_tok, num_prev_tok;

    // character classes and positions
    always_comb
    begin
        c        = item.char_byte;
        dval     = c[3:0];
        is_digit = (c inside {[8'h30:8'h39]});
        is_alpha = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_space = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
        cur      = pos_reg;
        prev     = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
        len_cur  = (cur >= start_reg) ? cur - start_reg : '0;
        len_prev = (prev >= start_reg) ? prev - start_reg : '0;
        mac      = mac10(acc_reg, dval);
        num_cur_tok  = make_tok(KIND_NUMBER, start_reg, len_cur, acc_reg, frac_reg, ovf_reg);
        num_prev_tok = make_tok(KIND_NUMBER, start_reg, len_prev, acc_reg, frac_reg, ovf_reg);
    end

    // next state and tokens
    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        ovf_next   = ovf_reg;
        mode_next  = mode_reg;
        scan       = 1'b0;
        flush_v    = 1'b0;
        byte_v     = 1'b0;
        flush_tok  = num_cur_tok;
        byte_tok   = make_tok(KIND_ERROR, cur, OFFSET_BITS'(1), '0, '0, 1'b0);

        if (accept && item.end_of_text) begin
            // flush pending token, then end token (an error token after a trailing dot)
            byte_v   = 1'b1;
            byte_tok = make_tok(KIND_END, cur, '0, '0, '0, 1'b0);
            case (mode_reg)
                MODE_INT, MODE_FRAC:
                begin
                    flush_v = 1'b1;
                end
                MODE_IDENT:
                begin
                    flush_v   = 1'b1;
                    flush_tok = make_tok(KIND_IDENT, start_reg, cur - start_reg,
                                         '0, '0, 1'b0);
                end
                MODE_STAR:
                begin
                    flush_v   = 1'b1;
                    flush_tok = make_tok(KIND_STAR, start_reg, OFFSET_BITS'(1),
                                         '0, '0, 1'b0);
                end
                MODE_DOT:
                begin
                    // number before the dot, then error on the dot, no end token
                    flush_v   = 1'b1;
                    flush_tok = num_prev_tok;
                    byte_tok  = make_tok(KIND_ERROR, prev, OFFSET_BITS'(1), '0, '0, 1'b0);
                end
                default:
                begin
                    flush_v = 1'b0;
                end
            endcase
            pos_next   = '0;
            start_next = '0;
            acc_next   = '0;
            frac_next  = '0;
            ovf_next   = 1'b0;
            mode_next  = MODE_IDLE;
        end
        else if (accept) begin
            if (pos_reg != '1) begin
                pos_next = pos_reg + 1'b1;
            end

            // pending token
            case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit) begin
                        acc_next = mac[MANTISSA_BITS-1:0];
                        ovf_next = ovf_reg | mac[MANTISSA_BITS];
                    end
                    else if (c == CH_DOT) begin
                        mode_next = MODE_DOT;
                    end
                    else if (c != CH_UNDERSCORE) begin
                        flush_v   = 1'b1;
                        mode_next = MODE_IDLE;
                        scan      = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (is_digit) begin
                        acc_next  = mac[MANTISSA_BITS-1:0];
                        ovf_next  = ovf_reg | mac[MANTISSA_BITS];
                        frac_next = (frac_reg < FRAC_MAX) ? frac_reg + 1'b1 : frac_reg;
                        mode_next = MODE_FRAC;
                    end
                    else begin
                        flush_v   = 1'b1;
                        flush_tok = num_prev_tok;
                        byte_v    = 1'b1;
                        byte_tok  = make_tok(KIND_ERROR, prev, OFFSET_BITS'(1),
                                             '0, '0, 1'b0);
                        mode_next = MODE_HALT;
                    end
                end
                MODE_FRAC:
                begin
                    if (is_digit) begin
                        acc_next  = mac[MANTISSA_BITS-1:0];
                        ovf_next  = ovf_reg | mac[MANTISSA_BITS];
                        frac_next = (frac_reg < FRAC_MAX) ? frac_reg + 1'b1 : frac_reg;
                    end
                    else if (c != CH_UNDERSCORE) begin
                        flush_v   = 1'b1;
                        mode_next = MODE_IDLE;
                        scan      = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    if (!(is_alpha || is_digit || c == CH_UNDERSCORE)) begin
                        flush_v   = 1'b1;
                        flush_tok = make_tok(KIND_IDENT, start_reg, cur - start_reg,
                                             '0, '0, 1'b0);
                        mode_next = MODE_IDLE;
                        scan      = 1'b1;
                    end
                end
                MODE_STAR:
                begin
                    mode_next = MODE_IDLE;
                    if (c == CH_STAR) begin
                        flush_v   = 1'b1;
                        flush_tok = make_tok(KIND_POWER, start_reg, OFFSET_BITS'(2),
                                             '0, '0, 1'b0);
                    end
                    else begin
                        flush_v   = 1'b1;
                        flush_tok = make_tok(KIND_STAR, start_reg, OFFSET_BITS'(1),
                                             '0, '0, 1'b0);
                        scan      = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    scan = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_HALT;
                end
            endcase

            // scan the byte from idle
            if (scan && !is_space) begin
                if (is_digit) begin
                    start_next = cur;
                    acc_next   = MANTISSA_BITS'(dval);
                    frac_next  = '0;
                    ovf_next   = 1'b0;
                    mode_next  = MODE_INT;
                end
                else if (is_alpha || c == CH_UNDERSCORE) begin
                    start_next = cur;
                    mode_next  = MODE_IDENT;
                end
                else begin
                    byte_v = 1'b1;
                    case (c)
                        CH_STAR:
                        begin
                            byte_v     = 1'b0;
                            start_next = cur;
                            mode_next  = MODE_STAR;
                        end
                        CH_PLUS:
                            byte_tok = make_tok(KIND_PLUS, cur, OFFSET_BITS'(1), '0, '0, 1'b0);
                        CH_MINUS:
                            byte_tok = make_tok(KIND_MINUS, cur, OFFSET_BITS'(1), '0, '0, 1'b0);
                        CH_SLASH:
                            byte_tok = make_tok(KIND_SLASH, cur, OFFSET_BITS'(1), '0, '0, 1'b0);
                        CH_LPAREN:
                            byte_tok = make_tok(KIND_LPAREN, cur, OFFSET_BITS'(1), '0, '0, 1'b0);
                        CH_RPAREN:
                            byte_tok = make_tok(KIND_RPAREN, cur, OFFSET_BITS'(1), '0, '0, 1'b0);
                        default:
                        begin
                            mode_next = MODE_HALT;
                        end
                    endcase
                end
            end
        end

        // order tokens: flushed token first
        emit.first_valid  = flush_v | byte_v;
        emit.second_valid = flush_v & byte_v;
        emit.first_tok    = flush_v ? flush_tok : byte_tok;
        emit.second_tok   = byte_tok;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg   <= '0;
            start_reg <= '0;
            acc_reg   <= '0;
            frac_reg  <= '0;
            ovf_reg   <= 1'b0;
            mode_reg  <= MODE_IDLE;
        end
        else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            ovf_reg   <= ovf_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

FILE: sv/ets_token_queue.sv
// ============================================================================
// ets_token_queue
// Four-entry token queue taking up to two tokens a cycle, giving one unless stalled.
// ============================================================================
`timescale 1ns / 1ps

module ets_token_queue
    import ets_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  emit_t     emit,
    output logic      full,
    output logic      tok_valid,
    input  logic      tok_stall,
    output out_item_t tok_item
);

    out_item_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_ADDR_BITS-1:0] head_reg, head_next;
    logic [QUEUE_ADDR_BITS-1:0] tail_reg, tail_next;
    logic [QUEUE_CNT_BITS-1:0]  count_reg, count_next;
    logic [QUEUE_CNT_BITS-1:0]  wr_n;
    logic                       rd;

    // room for two tokens is needed before an item is taken
    assign full      = count_reg > QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
    assign tok_valid = count_reg != '0;
    assign tok_item  = mem[head_reg];

    // pointer and count update
    always_comb
    begin
        rd         = tok_valid & ~tok_stall;
        wr_n       = QUEUE_CNT_BITS'(emit.first_valid) + QUEUE_CNT_BITS'(emit.second_valid);
        head_next  = rd ? head_reg + 1'b1 : head_reg;
        tail_next  = tail_reg + QUEUE_ADDR_BITS'(wr_n);
        count_next = count_reg + wr_n - QUEUE_CNT_BITS'(rd);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (emit.first_valid) begin
            mem[tail_reg] <= emit.first_tok;
        end
        if (emit.second_valid) begin
            mem[tail_reg + 1'b1] <= emit.second_tok;
        end
    end

endmodule

FILE: sv/expression_token_scanner.sv
// ============================================================================
// expression_token_scanner
// Streaming lexer for arithmetic expressions: one byte or end marker per item.
// ============================================================================
// Output: a token is written into the queue when the item completing it is accepted.
// Throughput: one item per cycle unless src_stall is high; an item yields
//   at most two tokens into a four-entry queue; src_stall rises while over two wait.
// Reset: rst_n clears the scanner state and empties the queue; the end
//   marker also returns the scanner to its reset state.
`timescale 1ns / 1ps

module expression_token_scanner
    import ets_pkg::*;
#(
    parameter int OFFSET_BITS   = 32,
    parameter int MANTISSA_BITS = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_item,
    output logic      tok_valid,
    input  logic      tok_stall,
    output out_item_t tok_item
);

    emit_t emit;
    logic  accept;
    logic  full;

    // item handshake
    assign src_stall = full;
    assign accept    = src_valid & ~full;

    ets_scan_core #(
        .OFFSET_BITS   (OFFSET_BITS),
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_item),
        .emit   (emit)
    );

    ets_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .full      (full),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule
